/* rtl/core/assert_macros.svh */
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, quiet while reset is high.
`define VCA_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, quiet while reset is high.
`define VCA_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

// Next-cycle implication that also holds across reset.
`define VCA_ASSERT_ALW(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

/* rtl/core/vca_pkg.sv */
// ----------------------------------------------------------------------------
// vca_pkg
// Shared types and constants of the vector cosine pipeline.
// ----------------------------------------------------------------------------
package vca_pkg;

   localparam int COS_W = 32;

   // side flags that travel with each item down the pipeline
   typedef struct packed {
      logic valid;
      logic neg;
      logic zero;
   } vca_flags_type;

endpackage

/* rtl/core/vca_front.sv */
// ----------------------------------------------------------------------------
// vca_front
// Three stages: component products, dot and norm sums, norm product and dot magnitude.
// ----------------------------------------------------------------------------
module vca_front #(
   parameter int COORD_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  logic signed [COORD_BITS-1:0]  a_x,
   input  logic signed [COORD_BITS-1:0]  a_y,
   input  logic signed [COORD_BITS-1:0]  a_z,
   input  logic signed [COORD_BITS-1:0]  b_x,
   input  logic signed [COORD_BITS-1:0]  b_y,
   input  logic signed [COORD_BITS-1:0]  b_z,
   output vca_pkg::vca_flags_type        out_flags,
   output logic [4*COORD_BITS-1:0]       out_p,
   output logic [2*COORD_BITS-1:0]       out_mag
);
   import vca_pkg::*;

   localparam int PW = 2*COORD_BITS;
   localparam int DW = 2*COORD_BITS + 1;

   // stage 1: products
   logic                 v1_ff;
   logic signed [PW-1:0] dx_ff, dy_ff, dz_ff;
   logic signed [PW-1:0] ax2_ff, ay2_ff, az2_ff, bx2_ff, by2_ff, bz2_ff;
   // stage 2: sums
   logic                 v2_ff;
   logic signed [DW-1:0] dot_ff, dot_in;
   logic [PW-1:0]        na_ff, nb_ff, na_in, nb_in;
   // stage 3: norm product, magnitude
   vca_flags_type        fl3_ff, fl3_in;
   logic [2*PW-1:0]      p_ff;
   logic [PW-1:0]        mag_ff, mag_in;
   logic signed [DW-1:0] dot_abs;

   always_comb begin
      dot_in = DW'(dx_ff) + DW'(dy_ff) + DW'(dz_ff);
      na_in  = $unsigned(ax2_ff) + $unsigned(ay2_ff) + $unsigned(az2_ff);
      nb_in  = $unsigned(bx2_ff) + $unsigned(by2_ff) + $unsigned(bz2_ff);
      dot_abs = dot_ff[DW-1] ? -dot_ff : dot_ff;
      mag_in = dot_abs[PW-1:0];
      fl3_in.valid = v2_ff;
      fl3_in.neg   = dot_ff[DW-1];
      fl3_in.zero  = (na_ff == '0) || (nb_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff  <= 1'b0;
         v2_ff  <= 1'b0;
         fl3_ff <= '0;
      end else if (en) begin
         v1_ff  <= in_valid;
         v2_ff  <= v1_ff;
         fl3_ff <= fl3_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dx_ff  <= a_x * b_x;
         dy_ff  <= a_y * b_y;
         dz_ff  <= a_z * b_z;
         ax2_ff <= a_x * a_x;
         ay2_ff <= a_y * a_y;
         az2_ff <= a_z * a_z;
         bx2_ff <= b_x * b_x;
         by2_ff <= b_y * b_y;
         bz2_ff <= b_z * b_z;
         dot_ff <= dot_in;
         na_ff  <= na_in;
         nb_ff  <= nb_in;
         p_ff   <= (2*PW)'(na_ff) * (2*PW)'(nb_ff);
         mag_ff <= mag_in;
      end
   end

   assign out_flags = fl3_ff;
   assign out_p     = p_ff;
   assign out_mag   = mag_ff;

endmodule

/* rtl/core/vca_sqrt.sv */
// ----------------------------------------------------------------------------
// vca_sqrt
// Pipelined integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module vca_sqrt #(
   parameter int ROOT_W = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  vca_pkg::vca_flags_type in_flags,
   input  logic [2*ROOT_W-1:0]    in_p,
   input  logic [ROOT_W-1:0]      in_mag,
   output vca_pkg::vca_flags_type out_flags,
   output logic [ROOT_W-1:0]      out_root,
   output logic [ROOT_W-1:0]      out_mag
);
   import vca_pkg::*;

   localparam int REM_W = ROOT_W + 2;
   localparam int P_W   = 2*ROOT_W;

   vca_flags_type     fl_ff   [ROOT_W];
   logic [REM_W-1:0]  rem_ff  [ROOT_W];
   logic [ROOT_W-1:0] root_ff [ROOT_W];
   logic [P_W-1:0]    p_ff    [ROOT_W];
   logic [ROOT_W-1:0] mag_ff  [ROOT_W];

   for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
      localparam int J    = ROOT_W - 1 - k;
      localparam int PREV = (k == 0) ? 0 : k - 1;
      vca_flags_type     fl_src;
      logic [REM_W-1:0]  rem_src, rem_sh, trial, rem_in;
      logic [ROOT_W-1:0] root_src, root_in, mag_src;
      logic [P_W-1:0]    p_src;

      assign fl_src   = (k == 0) ? in_flags : fl_ff[PREV];
      assign rem_src  = (k == 0) ? '0       : rem_ff[PREV];
      assign root_src = (k == 0) ? '0       : root_ff[PREV];
      assign p_src    = (k == 0) ? in_p     : p_ff[PREV];
      assign mag_src  = (k == 0) ? in_mag   : mag_ff[PREV];

      // bring down the next bit pair, try root*4+1
      always_comb begin
         rem_sh = {rem_src[REM_W-3:0], p_src[2*J+1 -: 2]};
         trial  = {root_src, 2'b01};
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_src[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_src[ROOT_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            fl_ff[k] <= '0;
         end else if (en) begin
            fl_ff[k] <= fl_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
            p_ff[k]    <= p_src;
            mag_ff[k]  <= mag_src;
         end
      end
   end

   assign out_flags = fl_ff[ROOT_W-1];
   assign out_root  = root_ff[ROOT_W-1];
   assign out_mag   = mag_ff[ROOT_W-1];

endmodule

/* rtl/core/vca_div.sv */
// ----------------------------------------------------------------------------
// vca_div
// Pipelined restoring divider: mag * 2^FRAC_BITS / root, one bit per stage.
// ----------------------------------------------------------------------------
module vca_div #(
   parameter int ROOT_W    = 32,
   parameter int FRAC_BITS = 30
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  vca_pkg::vca_flags_type in_flags,
   input  logic [ROOT_W-1:0]      in_root,
   input  logic [ROOT_W-1:0]      in_mag,
   output vca_pkg::vca_flags_type out_flags,
   output logic [FRAC_BITS:0]     out_quo
);
   import vca_pkg::*;

   localparam int NS  = FRAC_BITS + 1;
   localparam int R_W = ROOT_W + 1;

   vca_flags_type     fl_ff   [NS];
   logic [R_W-1:0]    rem_ff  [NS];
   logic [ROOT_W-1:0] div_ff  [NS];
   logic [FRAC_BITS:0] quo_ff [NS];

   for (genvar k = 0; k < NS; k++) begin : g_stage
      localparam int PREV = (k == 0) ? 0 : k - 1;
      vca_flags_type      fl_src;
      logic [R_W-1:0]     rem_src, cand, rem_in;
      logic [ROOT_W-1:0]  div_src;
      logic [FRAC_BITS:0] quo_src, quo_in;

      assign fl_src  = (k == 0) ? in_flags : fl_ff[PREV];
      assign rem_src = (k == 0) ? R_W'(in_mag) : rem_ff[PREV];
      assign div_src = (k == 0) ? in_root  : div_ff[PREV];
      assign quo_src = (k == 0) ? '0       : quo_ff[PREV];

      // integer bit first, then one fraction bit per stage
      always_comb begin
         cand = (k == 0) ? rem_src : {rem_src[ROOT_W-1:0], 1'b0};
         if (cand >= R_W'(div_src)) begin
            rem_in = cand - R_W'(div_src);
            quo_in = {quo_src[FRAC_BITS-1:0], 1'b1};
         end else begin
            rem_in = cand;
            quo_in = {quo_src[FRAC_BITS-1:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            fl_ff[k] <= '0;
         end else if (en) begin
            fl_ff[k] <= fl_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= rem_in;
            div_ff[k] <= div_src;
            quo_ff[k] <= quo_in;
         end
      end
   end

   assign out_flags = fl_ff[NS-1];
   assign out_quo   = quo_ff[NS-1];

endmodule

/* rtl/core/vector_cosine_angle.sv */
// ----------------------------------------------------------------------------
// vector_cosine_angle
// Cosine of the angle between two signed integer 3D vectors, fixed point.
// ----------------------------------------------------------------------------
// Takes one vector pair per cycle while req_ready is high and returns one
// item per pair, in order. Three front stages form the products, the dot
// product with both squared norms, and the product of the norms; a
// pipelined square root then yields one root bit per stage (2*COORD_BITS
// stages), a pipelined divider yields one quotient bit per stage
// (FRAC_BITS+1 stages), and an output stage applies sign, clamp and the
// zero-length case. A skid register behind the output holds one result
// while the consumer stalls; only when it is full does the pipeline
// freeze and req_ready drop. A zero-length vector gives zero_vector = 1
// and cosine = 0. Pass 2D vectors with z = 0.
// ----------------------------------------------------------------------------
module vector_cosine_angle #(
   parameter int COORD_BITS = 16,
   parameter int FRAC_BITS  = 30
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic signed [COORD_BITS-1:0]      req_a_x,
   input  logic signed [COORD_BITS-1:0]      req_a_y,
   input  logic signed [COORD_BITS-1:0]      req_a_z,
   input  logic signed [COORD_BITS-1:0]      req_b_x,
   input  logic signed [COORD_BITS-1:0]      req_b_y,
   input  logic signed [COORD_BITS-1:0]      req_b_z,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [vca_pkg::COS_W-1:0]  rsp_cosine,
   output logic                              rsp_zero_vector
);
   import vca_pkg::*;

   localparam int ROOT_W = 2*COORD_BITS;
   localparam logic [FRAC_BITS:0] LIMIT = (FRAC_BITS+1)'(1) << FRAC_BITS;

   // pipeline advances whenever the skid register is free
   logic en;

   vca_flags_type      fr_flags, sq_flags, dv_flags;
   logic [2*ROOT_W-1:0] fr_p;
   logic [ROOT_W-1:0]  fr_mag, sq_root, sq_mag;
   logic [FRAC_BITS:0] dv_quo, quo_sat;

   // output stage and skid register
   logic                    out_valid_ff;
   logic signed [COS_W-1:0] out_cos_ff, out_cos_in;
   logic                    out_zero_ff;
   logic                    skid_full_ff, skid_full_in;
   logic signed [COS_W-1:0] skid_cos_ff;
   logic                    skid_zero_ff;

   assign en        = !skid_full_ff;
   assign req_ready = en;

   vca_front #(.COORD_BITS(COORD_BITS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .a_x       (req_a_x),
      .a_y       (req_a_y),
      .a_z       (req_a_z),
      .b_x       (req_b_x),
      .b_y       (req_b_y),
      .b_z       (req_b_z),
      .out_flags (fr_flags),
      .out_p     (fr_p),
      .out_mag   (fr_mag)
   );

   vca_sqrt #(.ROOT_W(ROOT_W)) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_flags  (fr_flags),
      .in_p      (fr_p),
      .in_mag    (fr_mag),
      .out_flags (sq_flags),
      .out_root  (sq_root),
      .out_mag   (sq_mag)
   );

   vca_div #(.ROOT_W(ROOT_W), .FRAC_BITS(FRAC_BITS)) u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_flags  (sq_flags),
      .in_root   (sq_root),
      .in_mag    (sq_mag),
      .out_flags (dv_flags),
      .out_quo   (dv_quo)
   );

   // clamp to +-1.0, apply sign, force zero for a zero-length vector
   always_comb begin
      quo_sat = (dv_quo > LIMIT) ? LIMIT : dv_quo;
      if (dv_flags.zero) begin
         out_cos_in = '0;
      end else if (dv_flags.neg) begin
         out_cos_in = -$signed(COS_W'(quo_sat));
      end else begin
         out_cos_in = $signed(COS_W'(quo_sat));
      end
   end

   // fill the skid when the output item is about to be overwritten untaken;
   // drain it when the consumer takes it
   always_comb begin
      skid_full_in = skid_full_ff;
      if (skid_full_ff) begin
         if (rsp_ready) begin
            skid_full_in = 1'b0;
         end
      end else if (out_valid_ff && !rsp_ready) begin
         skid_full_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         skid_full_ff <= 1'b0;
      end else begin
         skid_full_ff <= skid_full_in;
         if (en) begin
            out_valid_ff <= dv_flags.valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_cos_ff  <= out_cos_in;
         out_zero_ff <= dv_flags.zero;
         skid_cos_ff  <= out_cos_ff;
         skid_zero_ff <= out_zero_ff;
      end
   end

   assign rsp_valid       = skid_full_ff || out_valid_ff;
   assign rsp_cosine      = skid_full_ff ? skid_cos_ff  : out_cos_ff;
   assign rsp_zero_vector = skid_full_ff ? skid_zero_ff : out_zero_ff;

endmodule

/* rtl/core/vca_checker.sv */
// ----------------------------------------------------------------------------
// vca_checker
// Port-level checks of the vector cosine block, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module vca_checker #(
   parameter int FRAC_BITS  = 30
) (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic signed [vca_pkg::COS_W-1:0]  rsp_cosine,
   input logic                              rsp_zero_vector
);
   import vca_pkg::*;

   localparam logic signed [COS_W-1:0] POS_ONE = COS_W'(1) << FRAC_BITS;
   localparam logic signed [COS_W-1:0] NEG_ONE = -POS_ONE;

   // a zero-length vector always reports zero cosine
   `VCA_ASSERT_IMP(a_zero_cos, clock, reset, rsp_valid && rsp_zero_vector, rsp_cosine == '0)

   // cosine stays within +-1.0
   `VCA_ASSERT_IMP(a_cos_range, clock, reset, rsp_valid, (rsp_cosine <= POS_ONE) && (rsp_cosine >= NEG_ONE))

   // a stalled result holds
   `VCA_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_cosine))

   // nothing comes out right after reset
   `VCA_ASSERT_ALW(a_reset_idle, clock, reset, !rsp_valid)

   // req_ready is high right after any cycle with no result waiting
   `VCA_ASSERT_NXT(a_skid_room, clock, reset, !rsp_valid, req_ready)

endmodule

bind vector_cosine_angle vca_checker #(
   .FRAC_BITS  (FRAC_BITS)
) u_vca_checker (.*);
